// ===== hw/rtl/wvba_pkg.sv =====
// Package for the weighted volume bias average block.
// Holds field widths, register indexes, controller states and the command/status structs.
// No dependencies.
package wvba_pkg;

  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int BIAS_W  = 48;
  localparam int QUOT_W  = BIAS_W;
  localparam int AVG_W   = 54;
  localparam int PROD_W  = QUOT_W + VOL_W;
  localparam int MUL_SPLIT = 24;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 2;
  localparam int BAR_W   = 8;
  localparam logic [BAR_W-1:0] BAR_CAP = 8'd128;

  localparam logic [IDX_W-1:0] REG_LONG_BIAS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_AVG    = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHORT_BIAS  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SHORT_AVG   = 2'd3;

  localparam logic [CFG_W-1:0] RST_LONG_BIAS  = 7'd32;
  localparam logic [CFG_W-1:0] RST_LONG_AVG   = 7'd16;
  localparam logic [CFG_W-1:0] RST_SHORT_BIAS = 7'd8;
  localparam logic [CFG_W-1:0] RST_SHORT_AVG  = 7'd4;

  localparam logic signed [BIAS_W-1:0] BIAS_MAX = {1'b0, {(BIAS_W-1){1'b1}}};
  localparam logic signed [BIAS_W-1:0] BIAS_MIN = {1'b1, {(BIAS_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SAT,
    ST_RD_LONG,
    ST_RD_SHORT,
    ST_WS_SHORT,
    ST_TOTAL,
    ST_AVG_GO,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic mul_lo;
    logic mul_hi;
    logic sat;
    logic rd_short;
    logic upd_long_ws;
    logic upd_short_ws;
    logic commit;
    logic avg_start;
    logic out_load;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic avg_done;
  } status_t;

endpackage

// ===== hw/rtl/wvba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wvba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/wvba_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module wvba_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem, acc[NUM_W-1]};
  assign take  = trial >= {1'b0, dvs};
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      rem <= take ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
      acc <= {acc[NUM_W-2:0], take};
    end
  end

endmodule

// ===== hw/rtl/wvba_ctrl.sv =====
// Controller state machine: sequences bias, ring updates and averaging.
// Depends on wvba_pkg.
module wvba_ctrl
  import wvba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = !rst && !cfg_valid;
        cfg_ready     = !rst && !out_valid;
        cmd.cfg_write = cfg_valid && cfg_ready;
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = ST_RD_LONG;
      end
      ST_RD_LONG: begin
        state_next = ST_RD_SHORT;
      end
      ST_RD_SHORT: begin
        cmd.rd_short    = 1'b1;
        cmd.upd_long_ws = 1'b1;
        state_next      = ST_WS_SHORT;
      end
      ST_WS_SHORT: begin
        cmd.rd_short     = 1'b1;
        cmd.upd_short_ws = 1'b1;
        state_next       = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd.commit = 1'b1;
        state_next = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        cmd.avg_start = 1'b1;
        state_next    = ST_AVG;
      end
      ST_AVG: begin
        if (status.avg_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_START)
    else $error("accepted bar did not start processing");
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result overwrote a pending transfer");
  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
  a_cfg_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.cfg_write |-> state == ST_IDLE && !cmd.commit)
    else $error("register write outside idle");
`endif

endmodule

// ===== hw/rtl/wvba_datapath.sv =====
// Datapath: bias divider and multiplier, bias and window-sum rings, totals, averaging.
// Depends on wvba_pkg, wvba_div and wvba_ram.
module wvba_datapath
  import wvba_pkg::*;
#(
  parameter int MAX_BIAS_WINDOW    = 64,
  parameter int MAX_AVERAGE_WINDOW = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [PRICE_W-1:0]         bar_high,
  input  logic [PRICE_W-1:0]         bar_low,
  input  logic [PRICE_W-1:0]         bar_open,
  input  logic [VOL_W-1:0]           volume_buy,
  input  logic [VOL_W-1:0]           volume_sell,
  output logic signed [AVG_W-1:0]    long_average,
  output logic                       long_valid,
  output logic signed [AVG_W-1:0]    short_average,
  output logic                       short_valid,
  output logic                       zero_open_flag
);

  localparam int BA_W   = MAX_BIAS_WINDOW > 1 ? $clog2(MAX_BIAS_WINDOW) : 1;
  localparam int AA_W   = MAX_AVERAGE_WINDOW > 1 ? $clog2(MAX_AVERAGE_WINDOW) : 1;
  localparam int P_W    = $clog2(MAX_BIAS_WINDOW + 1);
  localparam int N_W    = $clog2(MAX_AVERAGE_WINDOW + 1);
  localparam int SUM_W  = BIAS_W + $clog2(MAX_BIAS_WINDOW);
  localparam int TOT_W  = SUM_W + $clog2(MAX_AVERAGE_WINDOW);
  localparam int FILL_CAP = MAX_BIAS_WINDOW > MAX_AVERAGE_WINDOW ?
                            MAX_BIAS_WINDOW : MAX_AVERAGE_WINDOW;
  localparam int F_W    = $clog2(FILL_CAP + 1);
  localparam int THR_W  = (P_W > N_W ? P_W : N_W) + 1;
  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(BIAS_MAX);
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(BIAS_MAX) + PROD_W'(1);

  logic [CFG_W-1:0] reg_long_bias, reg_long_avg, reg_short_bias, reg_short_avg;
  logic [P_W-1:0]   p_long, p_short;
  logic [N_W-1:0]   n_long, n_short;

  function automatic logic [P_W-1:0] clamp_p(input logic [CFG_W-1:0] v);
    if (v == '0) return P_W'(1);
    if (32'(v) > MAX_BIAS_WINDOW) return P_W'(MAX_BIAS_WINDOW);
    return P_W'(v);
  endfunction

  function automatic logic [N_W-1:0] clamp_n(input logic [CFG_W-1:0] v);
    if (v == '0) return N_W'(1);
    if (32'(v) > MAX_AVERAGE_WINDOW) return N_W'(MAX_AVERAGE_WINDOW);
    return N_W'(v);
  endfunction

  assign p_long  = clamp_p(reg_long_bias);
  assign p_short = clamp_p(reg_short_bias);
  assign n_long  = clamp_n(reg_long_avg);
  assign n_short = clamp_n(reg_short_avg);

  // Input stage
  logic [PRICE_W-1:0] dmag;
  logic [VOL_W-1:0]   vmag;
  logic               neg, zero_open;
  logic [PRICE_W-1:0] bar_open_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dmag       <= bar_low > bar_high ? bar_low - bar_high
                                       : bar_high - bar_low;
      vmag       <= volume_sell > volume_buy ? volume_sell - volume_buy
                                             : volume_buy - volume_sell;
      neg        <= (bar_low > bar_high) != (volume_sell > volume_buy);
      zero_open  <= bar_open == '0;
      bar_open_q <= bar_open;
    end
  end

  // Bias quotient and product
  logic [QUOT_W-1:0] wmag;
  logic              div_done;

  wvba_div #(.NUM_W(QUOT_W), .DEN_W(PRICE_W)) u_bias_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({dmag, 16'h0000}),
    .den   (bar_open_q),
    .quot  (wmag),
    .done  (div_done)
  );

  logic [MUL_SPLIT+VOL_W-1:0]   prod_lo, prod_hi;
  logic [PROD_W-1:0]            prod;
  logic signed [BIAS_W-1:0]     bias;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod_lo <= wmag[MUL_SPLIT-1:0] * vmag;
    end
    if (cmd.mul_hi) begin
      prod_hi <= wmag[QUOT_W-1:MUL_SPLIT] * vmag;
    end
  end

  assign prod = {prod_hi, {MUL_SPLIT{1'b0}}} + PROD_W'(prod_lo);

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      if (zero_open) begin
        bias <= '0;
      end else if (neg && prod > LIM_NEG) begin
        bias <= BIAS_MIN;
      end else if (!neg && prod > LIM_POS) begin
        bias <= BIAS_MAX;
      end else if (neg) begin
        bias <= -$signed(prod[BIAS_W-1:0]);
      end else begin
        bias <= $signed(prod[BIAS_W-1:0]);
      end
    end
  end

  // Stream state
  logic [BA_W-1:0]         bptr;
  logic [AA_W-1:0]         aptr;
  logic [F_W-1:0]          fill;
  logic [BAR_W-1:0]        bar, bar_next;
  logic signed [SUM_W-1:0] lws, sws;
  logic signed [TOT_W-1:0] lt, st;
  logic                    lv, sv;

  function automatic logic [BA_W-1:0] bias_idx(input logic [BA_W-1:0] ptr,
                                                input logic [P_W-1:0] p);
    logic [P_W:0] s;
    s = (P_W+1)'(ptr) + (P_W+1)'(MAX_BIAS_WINDOW) - (P_W+1)'(p);
    if (s >= (P_W+1)'(MAX_BIAS_WINDOW)) return BA_W'(s - (P_W+1)'(MAX_BIAS_WINDOW));
    return BA_W'(s);
  endfunction

  function automatic logic [AA_W-1:0] sum_idx(input logic [AA_W-1:0] ptr,
                                               input logic [N_W-1:0] n);
    logic [N_W:0] s;
    s = (N_W+1)'(ptr) + (N_W+1)'(MAX_AVERAGE_WINDOW) - (N_W+1)'(n);
    if (s >= (N_W+1)'(MAX_AVERAGE_WINDOW))
      return AA_W'(s - (N_W+1)'(MAX_AVERAGE_WINDOW));
    return AA_W'(s);
  endfunction

  logic [BA_W-1:0]   braddr;
  logic [BIAS_W-1:0] brdata;
  logic [SUM_W-1:0]  lrdata, srdata;

  assign braddr = cmd.rd_short ? bias_idx(bptr, p_short) : bias_idx(bptr, p_long);

  wvba_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_BIAS_WINDOW)) u_bias_ring (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (bptr),
    .wdata (bias),
    .raddr (braddr),
    .rdata (brdata)
  );

  wvba_ram #(.WIDTH(SUM_W), .DEPTH(MAX_AVERAGE_WINDOW)) u_long_ring (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (aptr),
    .wdata (lws),
    .raddr (sum_idx(aptr, n_long)),
    .rdata (lrdata)
  );

  wvba_ram #(.WIDTH(SUM_W), .DEPTH(MAX_AVERAGE_WINDOW)) u_short_ring (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (aptr),
    .wdata (sws),
    .raddr (sum_idx(aptr, n_short)),
    .rdata (srdata)
  );

  logic signed [BIAS_W-1:0] old_bias;
  logic signed [SUM_W-1:0]  old_lsum, old_ssum;
  logic [THR_W-1:0]         thr_long, thr_short;

  assign old_bias  = (cmd.upd_long_ws && fill >= F_W'(p_long)) ||
                     (cmd.upd_short_ws && fill >= F_W'(p_short)) ?
                     $signed(brdata) : '0;
  assign old_lsum  = fill >= F_W'(n_long)  ? $signed(lrdata) : '0;
  assign old_ssum  = fill >= F_W'(n_short) ? $signed(srdata) : '0;
  assign bar_next  = bar == BAR_CAP ? bar : bar + 1'b1;
  assign thr_long  = THR_W'(p_long) + THR_W'(n_long) - THR_W'(1);
  assign thr_short = THR_W'(p_short) + THR_W'(n_short) - THR_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cmd.cfg_write) begin
      bptr <= '0;
      aptr <= '0;
      fill <= '0;
      bar  <= '0;
      lws  <= '0;
      sws  <= '0;
      lt   <= '0;
      st   <= '0;
    end else begin
      if (cmd.upd_long_ws) begin
        lws <= lws + SUM_W'(bias) - SUM_W'(old_bias);
      end
      if (cmd.upd_short_ws) begin
        sws <= sws + SUM_W'(bias) - SUM_W'(old_bias);
      end
      if (cmd.commit) begin
        lt   <= lt + TOT_W'(lws) - TOT_W'(old_lsum);
        st   <= st + TOT_W'(sws) - TOT_W'(old_ssum);
        bptr <= 32'(bptr) == MAX_BIAS_WINDOW - 1 ? '0 : bptr + 1'b1;
        aptr <= 32'(aptr) == MAX_AVERAGE_WINDOW - 1 ? '0 : aptr + 1'b1;
        fill <= fill == F_W'(FILL_CAP) ? fill : fill + 1'b1;
        bar  <= bar_next;
        lv   <= bar_next >= thr_long;
        sv   <= bar_next >= thr_short;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_long_bias  <= RST_LONG_BIAS;
      reg_long_avg   <= RST_LONG_AVG;
      reg_short_bias <= RST_SHORT_BIAS;
      reg_short_avg  <= RST_SHORT_AVG;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_LONG_BIAS:  reg_long_bias  <= cfg_data;
        REG_LONG_AVG:   reg_long_avg   <= cfg_data;
        REG_SHORT_BIAS: reg_short_bias <= cfg_data;
        REG_SHORT_AVG:  reg_short_avg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Averages
  logic [TOT_W-1:0]        lmag, smag, lquot, squot;
  logic signed [TOT_W-1:0] lq, sq;
  logic                    ldone, sdone;

  assign lmag = lt[TOT_W-1] ? TOT_W'(-lt) : TOT_W'(lt);
  assign smag = st[TOT_W-1] ? TOT_W'(-st) : TOT_W'(st);

  wvba_div #(.NUM_W(TOT_W), .DEN_W(N_W)) u_long_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.avg_start),
    .num   (lmag),
    .den   (n_long),
    .quot  (lquot),
    .done  (ldone)
  );

  wvba_div #(.NUM_W(TOT_W), .DEN_W(N_W)) u_short_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.avg_start),
    .num   (smag),
    .den   (n_short),
    .quot  (squot),
    .done  (sdone)
  );

  assign status.div_done = div_done;
  assign status.avg_done = ldone && sdone;

  assign lq = lt[TOT_W-1] ? -$signed(lquot) : $signed(lquot);
  assign sq = st[TOT_W-1] ? -$signed(squot) : $signed(squot);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      long_average   <= lv ? AVG_W'(lq) : '0;
      long_valid     <= lv;
      short_average  <= sv ? AVG_W'(sq) : '0;
      short_valid    <= sv;
      zero_open_flag <= zero_open;
    end
  end

endmodule

// ===== hw/rtl/weighted_volume_bias_average.sv =====
// Top level of the weighted volume bias average block.
// Depends on wvba_pkg, wvba_ctrl and wvba_datapath.
//
// One market bar is taken per transfer and yields one result transfer. A bar
// passes through the serial (high-low)/open division, which yields 48 quotient
// bits, the two serial averages, which run side by side on a 60-bit total at
// the defaults, and the control steps (accept, start, two multiply halves,
// saturate, ring reads and window-sum updates, commit, average start and
// output load). The next bar is taken while a finished result still waits in
// the output register; a second finished result stalls in the controller
// until that register empties. Register writes are taken only in idle with
// the output register empty, input is held off while a write is offered, and
// each write restarts averaging. No clearing pass follows reset.
module weighted_volume_bias_average
  import wvba_pkg::*;
#(
  parameter int MAX_BIAS_WINDOW    = 64,
  parameter int MAX_AVERAGE_WINDOW = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PRICE_W-1:0]      bar_high,
  input  logic [PRICE_W-1:0]      bar_low,
  input  logic [PRICE_W-1:0]      bar_open,
  input  logic [VOL_W-1:0]        volume_buy,
  input  logic [VOL_W-1:0]        volume_sell,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [AVG_W-1:0] long_average,
  output logic                    long_valid,
  output logic signed [AVG_W-1:0] short_average,
  output logic                    short_valid,
  output logic                    zero_open_flag,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  wvba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wvba_datapath #(
    .MAX_BIAS_WINDOW    (MAX_BIAS_WINDOW),
    .MAX_AVERAGE_WINDOW (MAX_AVERAGE_WINDOW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bar_high       (bar_high),
    .bar_low        (bar_low),
    .bar_open       (bar_open),
    .volume_buy     (volume_buy),
    .volume_sell    (volume_sell),
    .long_average   (long_average),
    .long_valid     (long_valid),
    .short_average  (short_average),
    .short_valid    (short_valid),
    .zero_open_flag (zero_open_flag)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for weighted_volume_bias_average: drives market bars and register
// writes, predicts each result in place and checks every result transfer.
// Depends on wvba_pkg and the weighted_volume_bias_average RTL.
module testbench
  import wvba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX = 64;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint BIAS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint BIAS_LO = -64'sh0000_8000_0000_0000;

  typedef struct {
    logic signed [AVG_W-1:0] long_avg;
    bit long_ok;
    logic signed [AVG_W-1:0] short_avg;
    bit short_ok;
    bit zero_open;
  } bar_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PRICE_W-1:0] bar_high = '0;
  logic [PRICE_W-1:0] bar_low = '0;
  logic [PRICE_W-1:0] bar_open = '0;
  logic [VOL_W-1:0] volume_buy = '0;
  logic [VOL_W-1:0] volume_sell = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AVG_W-1:0] long_average;
  logic long_valid;
  logic signed [AVG_W-1:0] short_average;
  logic short_valid;
  logic zero_open_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  weighted_volume_bias_average dut (.*);

  bar_result_t pending_results[$];
  int error_count = 0;
  longint cycle_count = 0;
  int hold_cycles = 0;
  int burst_left = 0;

  // predictor state
  bit [CFG_W-1:0] window_reg[4];
  longint bias_hist[WIN_MAX];
  int bias_wr;
  longint window_sum[2];
  longint sum_hist[2][WIN_MAX];
  int sum_wr[2];
  longint running_total[2];
  int bars_seen;

  initial forever #5 clk = ~clk;

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic void clear_history();
    bias_hist = '{default: 0};
    sum_hist = '{default: 0};
    window_sum = '{default: 0};
    running_total = '{default: 0};
    sum_wr = '{default: 0};
    bias_wr = 0;
    bars_seen = 0;
  endfunction

  function automatic int clamp_window(bit [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  function automatic longint bar_bias(bit [31:0] h, bit [31:0] l, bit [31:0] o,
                                      bit [31:0] b, bit [31:0] s);
    longint unsigned dmag, wmag, vmag, lim;
    bit dneg, vneg, neg;
    dneg = l > h;
    dmag = dneg ? 64'(l) - 64'(h) : 64'(h) - 64'(l);
    wmag = (dmag << 16) / 64'(o);
    vneg = s > b;
    vmag = vneg ? 64'(s) - 64'(b) : 64'(b) - 64'(s);
    neg = dneg != vneg;
    if (wmag == 0 || vmag == 0) return 0;
    lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (wmag > lim / vmag) return neg ? BIAS_LO : BIAS_HI;
    return neg ? -longint'(wmag * vmag) : longint'(wmag * vmag);
  endfunction

  function automatic bar_result_t predict_bar(bit [31:0] h, bit [31:0] l, bit [31:0] o,
                                              bit [31:0] b, bit [31:0] s);
    bar_result_t r;
    longint bias, avg[2];
    bit ok[2];
    int p, n, bidx, sidx;
    bias = (o == 0) ? 0 : bar_bias(h, l, o, b, s);
    if (bars_seen < BAR_CAP) bars_seen++;
    for (int k = 0; k < 2; k++) begin
      p = clamp_window(window_reg[2*k]);
      n = clamp_window(window_reg[2*k+1]);
      bidx = (bias_wr + WIN_MAX - p) % WIN_MAX;
      sidx = (sum_wr[k] + WIN_MAX - n) % WIN_MAX;
      window_sum[k] += bias - bias_hist[bidx];
      running_total[k] += window_sum[k] - sum_hist[k][sidx];
      sum_hist[k][sum_wr[k]] = window_sum[k];
      sum_wr[k] = (sum_wr[k] + 1) % WIN_MAX;
      ok[k] = bars_seen >= p + n - 1;
      avg[k] = ok[k] ? running_total[k] / longint'(n) : 0;
    end
    bias_hist[bias_wr] = bias;
    bias_wr = (bias_wr + 1) % WIN_MAX;
    r.long_avg = avg[0][AVG_W-1:0];
    r.long_ok = ok[0];
    r.short_avg = avg[1][AVG_W-1:0];
    r.short_ok = ok[1];
    r.zero_open = (o == 0);
    return r;
  endfunction

  task automatic send_bar(bit [31:0] h, bit [31:0] l, bit [31:0] o,
                          bit [31:0] b, bit [31:0] s);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid = 1'b1;
    bar_high = h;
    bar_low = l;
    bar_open = o;
    volume_buy = b;
    volume_sell = s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_bar(h, l, o, b, s));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_window(logic [IDX_W-1:0] idx, bit [CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    window_reg[idx] = value;
    clear_history();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_windows(int lp, int ls, int sp, int ss);
    drain_results();
    write_window(REG_LONG_BIAS, CFG_W'(lp));
    write_window(REG_LONG_AVG, CFG_W'(ls));
    write_window(REG_SHORT_BIAS, CFG_W'(sp));
    write_window(REG_SHORT_AVG, CFG_W'(ss));
  endtask

  task automatic send_random_bar();
    bit [31:0] h, l, o, b, s;
    int kind;
    kind = $urandom_range(0, 9);
    h = $urandom_range(32'h0001_0000, 32'h0100_0000);
    l = h - $urandom_range(0, h / 8);
    o = $urandom_range(32'h0001_0000, 32'h0100_0000);
    b = $urandom_range(0, 100000);
    s = $urandom_range(0, 100000);
    case (kind)
      0: begin
        h = $urandom; l = $urandom; o = $urandom; b = $urandom; s = $urandom;
      end
      1: begin
        h = $urandom; l = $urandom; o = $urandom_range(0, 3); b = $urandom; s = $urandom;
      end
      2: o = 0;
      3: begin
        l = $urandom; h = $urandom;
      end
      default: ;
    endcase
    send_bar(h, l, o, b, s);
  endtask

  task automatic test_directed_bars();
    send_bar(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 10, 4);
    send_bar(32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 10, 4);
    send_bar(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 10, 4);
    send_bar(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 4, 10);
    send_bar(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 4, 10);
    send_bar('1, '0, 32'h0000_0001, '1, '0);
    send_bar('1, '0, 32'h0000_0001, '0, '1);
    send_bar('0, '1, 32'h0000_0001, '1, '0);
    send_bar('0, '1, 32'h0000_0001, '0, '1);
    send_bar('1, '1, '1, '1, '1);
    send_bar('0, '0, '0, '0, '0);
    send_bar('1, '0, '1, 32'd1, 32'd0);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_bar(32'h0000_0001, 32'h0000_0000, '1, 32'd7, 32'd7);
    for (int i = 0; i < 8; i++) send_random_bar();
  endtask

  task automatic test_window_extremes();
    set_windows(1, 1, 1, 1);
    repeat (20) send_random_bar();
    set_windows(0, 0, 0, 0);
    repeat (20) send_random_bar();
    set_windows(64, 64, 64, 64);
    repeat (150) send_random_bar();
    set_windows(127, 127, 127, 127);
    repeat (150) send_random_bar();
    set_windows(64, 1, 1, 64);
    repeat (80) send_random_bar();
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_cycles = 1500;
    burst_left = 20;
    repeat (12) send_bar($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 16; phase++) begin
      set_windows($urandom_range(0, 127) % 20, $urandom_range(0, 20),
                  $urandom_range(0, 127), $urandom_range(0, 12));
      repeat (95) send_random_bar();
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      case ((cycle_count / 256) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    bar_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (long_average !== want.long_avg) begin
          $error("long_average: expected %0d, got %0d", want.long_avg, long_average);
          error_count++;
        end
        if (long_valid !== want.long_ok) begin
          $error("long_valid: expected %0d, got %0d", want.long_ok, long_valid);
          error_count++;
        end
        if (short_average !== want.short_avg) begin
          $error("short_average: expected %0d, got %0d", want.short_avg, short_average);
          error_count++;
        end
        if (short_valid !== want.short_ok) begin
          $error("short_valid: expected %0d, got %0d", want.short_ok, short_valid);
          error_count++;
        end
        if (zero_open_flag !== want.zero_open) begin
          $error("zero_open_flag: expected %0d, got %0d", want.zero_open, zero_open_flag);
          error_count++;
        end
      end
    end
  end

  initial begin
    window_reg[REG_LONG_BIAS] = RST_LONG_BIAS;
    window_reg[REG_LONG_AVG] = RST_LONG_AVG;
    window_reg[REG_SHORT_BIAS] = RST_SHORT_BIAS;
    window_reg[REG_SHORT_AVG] = RST_SHORT_AVG;
    clear_history();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_bars();
    repeat (60) send_random_bar();
    test_window_extremes();
    test_backpressure();
    test_random_stream();
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
